// ===== rtl/catmull_rom_spline_eval_macros.svh =====
// assertion macros shared by the checker of the spline evaluator
`ifndef CATMULL_ROM_SPLINE_EVAL_MACROS_SVH
`define CATMULL_ROM_SPLINE_EVAL_MACROS_SVH

// same-cycle implication under clock and active-low reset
`define CRS_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication under clock and active-low reset
`define CRS_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/crs_pkg.sv =====
// shared types and constants of the spline evaluator
package crs_pkg;

  localparam int unsigned COORD_W  = 32;
  localparam int unsigned POS_W    = 17;
  localparam int unsigned REQ_W    = 2;
  localparam int unsigned STS_W    = 2;
  localparam int unsigned ACC_W    = 37;
  localparam int unsigned PROD_W   = ACC_W + POS_W + 1;
  localparam int unsigned NUM_AXES = 3;
  localparam int unsigned NUM_TAPS = 4;
  localparam int unsigned MIN_POINTS = 4;
  localparam int unsigned IN_DATA_W  = 120;
  localparam int unsigned OUT_DATA_W = NUM_AXES * COORD_W;

  localparam logic [POS_W-1:0] ONE_Q16 = 17'h10000;

  localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_APPEND = 2'd1;
  localparam logic [REQ_W-1:0] REQ_EVAL   = 2'd2;

  localparam logic [STS_W-1:0] STS_OK    = 2'd0;
  localparam logic [STS_W-1:0] STS_RANGE = 2'd1;
  localparam logic [STS_W-1:0] STS_FEW   = 2'd2;
  localparam logic [STS_W-1:0] STS_FULL  = 2'd3;

  localparam logic [1:0] STEP_C = 2'd0;
  localparam logic [1:0] STEP_B = 2'd1;
  localparam logic [1:0] STEP_A = 2'd2;

  typedef struct packed {
    logic       accept;
    logic       seg_mul;
    logic       seg_idx;
    logic       rd_en;
    logic [1:0] rd_sel;
    logic       coef;
    logic       mul;
    logic       add;
    logic [1:0] step;
    logic       fin;
  } dp_cmd_t;

  typedef struct packed {
    logic eval_go;
  } dp_sts_t;

endpackage

// ===== rtl/crs_ctrl.sv =====
// sequencer of the spline evaluator: handshakes and evaluation steps
module crs_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  input  crs_pkg::dp_sts_t sts_i,
  output crs_pkg::dp_cmd_t cmd_o
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SEGM  = 4'd1;
  localparam logic [3:0] S_SEGI  = 4'd2;
  localparam logic [3:0] S_RD    = 4'd3;
  localparam logic [3:0] S_DRAIN = 4'd4;
  localparam logic [3:0] S_COEF  = 4'd5;
  localparam logic [3:0] S_MUL   = 4'd6;
  localparam logic [3:0] S_ADD   = 4'd7;
  localparam logic [3:0] S_FIN   = 4'd8;

  logic [3:0] state_q, state_d;
  logic [1:0] cnt_q, cnt_d;
  logic       out_vld_q, out_vld_d;
  logic       accept;

  assign s_axis_tready = (state_q == S_IDLE) && (!out_vld_q || m_axis_tready);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_vld_q;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    cmd_o.accept = accept;
    cmd_o.rd_sel = cnt_q;
    cmd_o.step   = cnt_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept && sts_i.eval_go) begin
          state_d = S_SEGM;
        end
      end
      S_SEGM: begin
        cmd_o.seg_mul = 1'b1;
        state_d = S_SEGI;
      end
      S_SEGI: begin
        cmd_o.seg_idx = 1'b1;
        cnt_d   = 2'd0;
        state_d = S_RD;
      end
      S_RD: begin
        cmd_o.rd_en = 1'b1;
        cnt_d = cnt_q + 2'd1;
        if (cnt_q == 2'd3) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_d = S_COEF;
      end
      S_COEF: begin
        cmd_o.coef = 1'b1;
        cnt_d   = crs_pkg::STEP_C;
        state_d = S_MUL;
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d = S_ADD;
      end
      S_ADD: begin
        cmd_o.add = 1'b1;
        cnt_d = cnt_q + 2'd1;
        state_d = (cnt_q == crs_pkg::STEP_A) ? S_FIN : S_MUL;
      end
      S_FIN: begin
        cmd_o.fin = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (m_axis_tvalid && m_axis_tready) begin
      out_vld_d = 1'b0;
    end
    if ((accept && !sts_i.eval_go) || cmd_o.fin) begin
      out_vld_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cnt_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      out_vld_q <= out_vld_d;
    end
  end

endmodule

// ===== rtl/crs_dp.sv =====
// datapath of the spline evaluator: point table, segment map, horner lanes
module crs_dp #(
  parameter int unsigned MAX_POINTS = 256
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic [crs_pkg::IN_DATA_W-1:0]        s_axis_tdata,
  input  logic [crs_pkg::REQ_W-1:0]            s_axis_tuser,
  output logic [crs_pkg::OUT_DATA_W-1:0]       m_axis_tdata,
  output logic [crs_pkg::STS_W-1:0]            m_axis_tuser,
  input  crs_pkg::dp_cmd_t                     cmd_i,
  output crs_pkg::dp_sts_t                     sts_o
);

  localparam int unsigned CW = $clog2(MAX_POINTS + 1);
  localparam int unsigned AW = $clog2(MAX_POINTS);
  localparam int unsigned SW = crs_pkg::POS_W + CW;
  localparam int unsigned CO = crs_pkg::COORD_W;
  localparam int unsigned AC = crs_pkg::ACC_W;

  logic [CO-1:0] x_mem [MAX_POINTS];
  logic [CO-1:0] y_mem [MAX_POINTS];
  logic [CO-1:0] z_mem [MAX_POINTS];

  logic [CW-1:0] count_q;
  logic [CO-1:0] in_x, in_y, in_z;
  logic [crs_pkg::POS_W-1:0] in_pos, pos_q;
  logic          full, few, pos_bad;
  logic [CW-1:0] segs;
  logic [SW-1:0] s_q;
  logic [CW:0]   idx_raw;
  logic [AW-1:0] idx_q, rd_addr;
  logic [crs_pkg::POS_W-1:0] t_q;
  logic          cap_en_q;
  logic [1:0]    cap_sel_q;
  logic [CO-1:0] rdata_q [crs_pkg::NUM_AXES];
  logic signed [CO-1:0] p_q [crs_pkg::NUM_AXES][crs_pkg::NUM_TAPS];
  logic signed [AC-1:0] a_q [crs_pkg::NUM_AXES];
  logic signed [AC-1:0] b_q [crs_pkg::NUM_AXES];
  logic signed [AC-1:0] c_q [crs_pkg::NUM_AXES];
  logic signed [AC-1:0] acc_q [crs_pkg::NUM_AXES];
  logic signed [crs_pkg::PROD_W-1:0] prod_q [crs_pkg::NUM_AXES];
  logic signed [AC-1:0] coef_sel [crs_pkg::NUM_AXES];
  logic signed [AC-1:0] pe [crs_pkg::NUM_AXES][crs_pkg::NUM_TAPS];
  logic signed [crs_pkg::PROD_W-1:0] rnd [crs_pkg::NUM_AXES];
  logic signed [AC:0]   half [crs_pkg::NUM_AXES];
  logic [CO-1:0]        res [crs_pkg::NUM_AXES];
  logic [crs_pkg::STS_W-1:0] imm_sts;

  assign in_x   = s_axis_tdata[CO-1:0];
  assign in_y   = s_axis_tdata[2*CO-1:CO];
  assign in_z   = s_axis_tdata[3*CO-1:2*CO];
  assign in_pos = s_axis_tdata[3*CO+crs_pkg::POS_W-1:3*CO];

  assign full    = count_q >= CW'(MAX_POINTS);
  assign few     = count_q < CW'(crs_pkg::MIN_POINTS);
  assign pos_bad = in_pos > crs_pkg::ONE_Q16;
  assign segs    = count_q - CW'(3);
  assign sts_o.eval_go = (s_axis_tuser == crs_pkg::REQ_EVAL) && !pos_bad && !few;

  always_comb begin
    case (s_axis_tuser)
      crs_pkg::REQ_APPEND: imm_sts = full ? crs_pkg::STS_FULL : crs_pkg::STS_OK;
      crs_pkg::REQ_EVAL: begin
        if (pos_bad) begin
          imm_sts = crs_pkg::STS_RANGE;
        end else if (few) begin
          imm_sts = crs_pkg::STS_FEW;
        end else begin
          imm_sts = crs_pkg::STS_OK;
        end
      end
      default: imm_sts = crs_pkg::STS_OK;
    endcase
  end

  // point count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.accept) begin
      if (s_axis_tuser == crs_pkg::REQ_CLEAR) begin
        count_q <= '0;
      end else if (s_axis_tuser == crs_pkg::REQ_APPEND && !full) begin
        count_q <= count_q + CW'(1);
      end
    end
  end

  // point table, one write port and one registered read port per axis
  assign rd_addr = idx_q + AW'(cmd_i.rd_sel) - AW'(1);

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && s_axis_tuser == crs_pkg::REQ_APPEND && !full) begin
      x_mem[count_q[AW-1:0]] <= in_x;
      y_mem[count_q[AW-1:0]] <= in_y;
      z_mem[count_q[AW-1:0]] <= in_z;
    end
    rdata_q[0] <= x_mem[rd_addr];
    rdata_q[1] <= y_mem[rd_addr];
    rdata_q[2] <= z_mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_en_q  <= 1'b0;
      cap_sel_q <= '0;
    end else begin
      cap_en_q  <= cmd_i.rd_en;
      cap_sel_q <= cmd_i.rd_sel;
    end
  end

  // segment index and fraction
  assign idx_raw = (CW+1)'(s_q[SW-1:16]) + (CW+1)'(1);

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      pos_q <= in_pos;
    end
    if (cmd_i.seg_mul) begin
      s_q <= SW'(pos_q) * SW'(segs);
    end
    if (cmd_i.seg_idx) begin
      if (idx_raw > {1'b0, segs}) begin
        idx_q <= AW'(segs);
        t_q   <= crs_pkg::ONE_Q16;
      end else begin
        idx_q <= AW'(idx_raw);
        t_q   <= {1'b0, s_q[15:0]};
      end
    end
  end

  // lanes, one per axis
  always_comb begin
    for (int i = 0; i < crs_pkg::NUM_AXES; i++) begin
      for (int j = 0; j < crs_pkg::NUM_TAPS; j++) begin
        pe[i][j] = AC'(p_q[i][j]);
      end
      case (cmd_i.step)
        crs_pkg::STEP_C: coef_sel[i] = c_q[i];
        crs_pkg::STEP_B: coef_sel[i] = b_q[i];
        default:         coef_sel[i] = a_q[i];
      endcase
      rnd[i]  = prod_q[i] + crs_pkg::PROD_W'(32768);
      half[i] = ((AC+1)'(acc_q[i]) + (AC+1)'(1)) >>> 1;
      // saturate when the bits above the sign of a 32-bit result disagree
      if (half[i][AC:CO-1] == '0 || half[i][AC:CO-1] == '1) begin
        res[i] = half[i][CO-1:0];
      end else if (half[i][AC]) begin
        res[i] = {1'b1, {(CO-1){1'b0}}};
      end else begin
        res[i] = {1'b0, {(CO-1){1'b1}}};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < crs_pkg::NUM_AXES; i++) begin
      if (cap_en_q) begin
        p_q[i][cap_sel_q] <= rdata_q[i];
      end
      if (cmd_i.coef) begin
        a_q[i]   <= pe[i][1] <<< 1;
        b_q[i]   <= pe[i][2] - pe[i][0];
        c_q[i]   <= (pe[i][0] <<< 1) - (pe[i][1] <<< 2) - pe[i][1]
                    + (pe[i][2] <<< 2) - pe[i][3];
        acc_q[i] <= (pe[i][1] <<< 1) + pe[i][1] - pe[i][0]
                    - (pe[i][2] <<< 1) - pe[i][2] + pe[i][3];
      end
      if (cmd_i.mul) begin
        prod_q[i] <= crs_pkg::PROD_W'(acc_q[i]) * $signed({1'b0, t_q});
      end
      if (cmd_i.add) begin
        acc_q[i] <= AC'(rnd[i] >>> 16) + coef_sel[i];
      end
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.fin) begin
      m_axis_tdata <= {res[2], res[1], res[0]};
      m_axis_tuser <= crs_pkg::STS_OK;
    end else if (cmd_i.accept && !sts_o.eval_go) begin
      m_axis_tdata <= '0;
      m_axis_tuser <= imm_sts;
    end
  end

endmodule

// ===== rtl/catmull_rom_spline_eval.sv =====
// top level of the uniform catmull-rom spline evaluator
//
//  channel   dir  tdata                                      tuser
//  s_axis    in   point_x, point_y, point_z, position, pad (120)  req_type
//  m_axis    out  value_x, value_y, value_z (96)             status
//
// clear and append give their transaction on m_axis the cycle after acceptance.
// an evaluate that passes its checks runs from acceptance to result through segment multiply, index,
// four reads of the point table's registered read port, coefficients, three multiply/add
// horner steps and saturation. one request is in flight at a time.
// reset empties the table; table contents stay undefined until written.
// a stalled m_axis holds the result and blocks acceptance of the next request.
module catmull_rom_spline_eval #(
  parameter int unsigned MAX_POINTS = 256
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // point_x[31:0], point_y[63:32], point_z[95:64], position[112:96], zero pad
  input  logic [crs_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  // req_type[1:0]
  input  logic [crs_pkg::REQ_W-1:0]         s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // value_x[31:0], value_y[63:32], value_z[95:64]
  output logic [crs_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  // status[1:0]
  output logic [crs_pkg::STS_W-1:0]         m_axis_tuser
);

  crs_pkg::dp_cmd_t cmd;
  crs_pkg::dp_sts_t sts;

  crs_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .sts_i         (sts),
    .cmd_o         (cmd)
  );

  crs_dp #(
    .MAX_POINTS (MAX_POINTS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .cmd_i        (cmd),
    .sts_o        (sts)
  );

endmodule

// ===== rtl/crs_checker.sv =====
// port-level checks of the spline evaluator and their binding
`include "catmull_rom_spline_eval_macros.svh"

module crs_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_axis_tvalid,
  input logic                           s_axis_tready,
  input logic [crs_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  input logic [crs_pkg::REQ_W-1:0]      s_axis_tuser,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [crs_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input logic [crs_pkg::STS_W-1:0]      m_axis_tuser
);

  // a result that waits keeps its value
  `CRS_ASSERT_NXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

  // any non-ok status carries zero values
  `CRS_ASSERT_IMP(a_err_zero, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser != crs_pkg::STS_OK, m_axis_tdata == '0)

  // an accepted transaction either shows its result next or keeps input closed
  `CRS_ASSERT_NXT(a_acc_busy, clk_i, rst_ni, s_axis_tvalid && s_axis_tready, m_axis_tvalid || !s_axis_tready)

  // input is never open while a pending result is not being taken
  `CRS_ASSERT_IMP(a_no_overrun, clk_i, rst_ni, s_axis_tready && m_axis_tvalid, m_axis_tready)

endmodule

bind catmull_rom_spline_eval crs_checker u_crs_checker (.*);

// ===== verif/catmull_rom_spline_eval_tb.sv =====
// testbench of the catmull-rom spline evaluator: table requests and evaluations checked per transaction
module catmull_rom_spline_eval_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned TABLE_DEPTH = 256;
  localparam int unsigned IDLE_LIMIT  = 20000;

  typedef struct packed {
    logic [crs_pkg::COORD_W-1:0] vx;
    logic [crs_pkg::COORD_W-1:0] vy;
    logic [crs_pkg::COORD_W-1:0] vz;
    logic [crs_pkg::STS_W-1:0]   sts;
  } spline_out_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [crs_pkg::IN_DATA_W-1:0] s_axis_tdata = '0;
  logic [crs_pkg::REQ_W-1:0] s_axis_tuser = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [crs_pkg::OUT_DATA_W-1:0] m_axis_tdata;
  logic [crs_pkg::STS_W-1:0] m_axis_tuser;

  catmull_rom_spline_eval #(.MAX_POINTS(TABLE_DEPTH)) dut (.*);

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // predictor copy of the point table
  longint pt_x[TABLE_DEPTH];
  longint pt_y[TABLE_DEPTH];
  longint pt_z[TABLE_DEPTH];
  int unsigned pt_count;
  spline_out_t spline_expected[$];
  int unsigned fail_count;
  int unsigned eval_ok_count, status_seen[4];
  bit rx_hold;
  int unsigned idle_cycles;

  function automatic longint rshift_floor(longint v, int k);
    return v >>> k;
  endfunction

  function automatic logic [31:0] spline_axis(longint p0, longint p1, longint p2, longint p3,
                                              longint t);
    longint c2, c1, c0, acc, r;
    c2 = 2 * p0 - 5 * p1 + 4 * p2 - p3;
    c1 = p2 - p0;
    c0 = 2 * p1;
    acc = 3 * p1 - p0 - 3 * p2 + p3;
    acc = rshift_floor(acc * t + 32768, 16) + c2;
    acc = rshift_floor(acc * t + 32768, 16) + c1;
    acc = rshift_floor(acc * t + 32768, 16) + c0;
    r = rshift_floor(acc + 1, 1);
    if (r > 64'sd2147483647) r = 64'sd2147483647;
    if (r < -64'sd2147483648) r = -64'sd2147483648;
    return r[31:0];
  endfunction

  function automatic spline_out_t predict_spline(logic [crs_pkg::REQ_W-1:0] req,
                                                 logic [31:0] px, logic [31:0] py,
                                                 logic [31:0] pz,
                                                 logic [crs_pkg::POS_W-1:0] pos);
    spline_out_t o;
    longint unsigned s, segs, idx;
    longint t;
    o = '0;
    o.sts = crs_pkg::STS_OK;
    if (req == crs_pkg::REQ_CLEAR) begin
      pt_count = 0;
    end else if (req == crs_pkg::REQ_APPEND) begin
      if (pt_count >= TABLE_DEPTH) begin
        o.sts = crs_pkg::STS_FULL;
      end else begin
        pt_x[pt_count] = longint'(signed'(px));
        pt_y[pt_count] = longint'(signed'(py));
        pt_z[pt_count] = longint'(signed'(pz));
        pt_count++;
      end
    end else if (req == crs_pkg::REQ_EVAL) begin
      if (pos > crs_pkg::ONE_Q16) begin
        o.sts = crs_pkg::STS_RANGE;
      end else if (pt_count < crs_pkg::MIN_POINTS) begin
        o.sts = crs_pkg::STS_FEW;
      end else begin
        segs = pt_count - 3;
        s = longint'(pos) * segs;
        idx = (s >> 16) + 1;
        t = longint'(s & 64'hFFFF);
        if (idx > segs) begin
          idx = segs;
          t = 65536;
        end
        o.vx = spline_axis(pt_x[idx-1], pt_x[idx], pt_x[idx+1], pt_x[idx+2], t);
        o.vy = spline_axis(pt_y[idx-1], pt_y[idx], pt_y[idx+1], pt_y[idx+2], t);
        o.vz = spline_axis(pt_z[idx-1], pt_z[idx], pt_z[idx+1], pt_z[idx+2], t);
      end
    end
    return o;
  endfunction

  function automatic int unsigned short_or_long_gap();
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
    if ($urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 3);
  endfunction

  task automatic send_request(logic [crs_pkg::REQ_W-1:0] req, logic [31:0] px,
                              logic [31:0] py, logic [31:0] pz,
                              logic [crs_pkg::POS_W-1:0] pos);
    int unsigned gap;
    spline_out_t pred;
    gap = short_or_long_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= req;
    s_axis_tdata <= {7'd0, pos, pz, py, px};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pred = predict_spline(req, px, py, pz, pos);
    spline_expected.insert(spline_expected.size(), pred);
    status_seen[pred.sts]++;
    if (req == crs_pkg::REQ_EVAL && pred.sts == crs_pkg::STS_OK) eval_ok_count++;
  endtask

  task automatic drain_and_idle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (spline_expected.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'($urandom_range(0, 2000000)) - 32'd1000000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [crs_pkg::POS_W-1:0] rand_pos();
    case ($urandom_range(0, 9))
      0: return crs_pkg::ONE_Q16;
      1: return '0;
      2: return crs_pkg::POS_W'($urandom_range(65537, 131071));
      default: return crs_pkg::POS_W'($urandom_range(0, 65536));
    endcase
  endfunction

  // result checker and receiver stall
  always @(posedge clk_i) begin
    spline_out_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (spline_expected.size() == 0) begin
        $display("%0t unexpected transaction: actual %h/%0d", $time, m_axis_tdata,
                 m_axis_tuser);
        fail_count++;
      end else begin
        want = spline_expected.pop_front();
        if (m_axis_tdata[31:0] !== want.vx) begin
          $display("%0t value_x expected %h actual %h", $time, want.vx, m_axis_tdata[31:0]);
          fail_count++;
        end
        if (m_axis_tdata[63:32] !== want.vy) begin
          $display("%0t value_y expected %h actual %h", $time, want.vy, m_axis_tdata[63:32]);
          fail_count++;
        end
        if (m_axis_tdata[95:64] !== want.vz) begin
          $display("%0t value_z expected %h actual %h", $time, want.vz, m_axis_tdata[95:64]);
          fail_count++;
        end
        if (m_axis_tuser !== want.sts) begin
          $display("%0t status expected %0d actual %0d", $time, want.sts, m_axis_tuser);
          fail_count++;
        end
      end
    end
  end

  initial begin
    int unsigned stall;
    forever begin
      @(posedge clk_i);
      if (rx_hold) begin
        m_axis_tready <= 1'b0;
        stall = 0;
        while (stall < 300) begin
          @(posedge clk_i);
          stall++;
        end
        rx_hold = 1'b0;
      end
      stall = short_or_long_gap();
      if (stall == 0 || $urandom_range(0, 3) != 0) m_axis_tready <= 1'b1;
      else begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
    end
  end

  // watchdog on cycles with no accepted transaction
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic test_directed();
    send_request(crs_pkg::REQ_EVAL, '0, '0, '0, '0);
    send_request(crs_pkg::REQ_EVAL, '0, '0, '0, 17'h1FFFF);
    send_request(crs_pkg::REQ_APPEND, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000, '0);
    send_request(crs_pkg::REQ_APPEND, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_0000, '0);
    send_request(crs_pkg::REQ_APPEND, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0002_0000, '0);
    send_request(crs_pkg::REQ_EVAL, '0, '0, '0, 17'h08000);
    send_request(crs_pkg::REQ_APPEND, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_8000, '0);
    send_request(crs_pkg::REQ_EVAL, '0, '0, '0, '0);
    send_request(crs_pkg::REQ_EVAL, '0, '0, '0, crs_pkg::ONE_Q16);
    send_request(crs_pkg::REQ_EVAL, '0, '0, '0, 17'h10001);
    send_request(crs_pkg::REQ_EVAL, '0, '0, '0, 17'h08000);
    send_request(2'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 17'h1FFFF);
    send_request(crs_pkg::REQ_CLEAR, '0, '0, '0, '0);
    send_request(crs_pkg::REQ_EVAL, '0, '0, '0, 17'h04000);
    drain_and_idle();
  endtask

  task automatic test_full_table();
    send_request(crs_pkg::REQ_CLEAR, '0, '0, '0, '0);
    for (int i = 0; i < TABLE_DEPTH + 2; i++)
      send_request(crs_pkg::REQ_APPEND, rand_coord(), rand_coord(), rand_coord(), '0);
    for (int i = 0; i < 12; i++) send_request(crs_pkg::REQ_EVAL, '0, '0, '0, rand_pos());
    send_request(crs_pkg::REQ_EVAL, '0, '0, '0, crs_pkg::ONE_Q16);
    drain_and_idle();
  endtask

  task automatic test_backpressure();
    rx_hold = 1'b1;
    for (int i = 0; i < 10; i++) send_request(crs_pkg::REQ_EVAL, '0, '0, '0, rand_pos());
    drain_and_idle();
  endtask

  // mostly well-formed curves: a clear, a handful of points, then several evaluations; else one random request
  task automatic test_random_curves(int unsigned items);
    int unsigned sent, npts, nevals;
    sent = 0;
    while (sent < items) begin
      if ($urandom_range(0, 9) == 0) begin
        send_request(2'($urandom_range(0, 3)), $urandom, $urandom, $urandom,
                     crs_pkg::POS_W'($urandom));
        sent++;
      end else begin
        send_request(crs_pkg::REQ_CLEAR, $urandom, $urandom, $urandom,
                     crs_pkg::POS_W'($urandom));
        npts = $urandom_range(0, 3) == 0 ? $urandom_range(0, 5) : $urandom_range(4, 12);
        for (int i = 0; i < npts; i++)
          send_request(crs_pkg::REQ_APPEND, rand_coord(), rand_coord(), rand_coord(),
                       crs_pkg::POS_W'($urandom));
        nevals = $urandom_range(2, 8);
        for (int i = 0; i < nevals; i++)
          send_request(crs_pkg::REQ_EVAL, $urandom, $urandom, $urandom, rand_pos());
        sent += 1 + npts + nevals;
      end
    end
    drain_and_idle();
  endtask

  initial begin
    pt_count = 0;
    fail_count = 0;
    eval_ok_count = 0;
    rx_hold = 1'b0;
    idle_cycles = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_full_table();
    test_backpressure();
    test_random_curves(400);
    repeat (40) @(posedge clk_i);
    $display("covered %0d good evaluations; status counts ok %0d range %0d few %0d full %0d",
             eval_ok_count, status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
    if (fail_count == 0 && spline_expected.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/crs_pkg.sv
rtl/crs_ctrl.sv
rtl/crs_dp.sv
rtl/catmull_rom_spline_eval.sv
rtl/crs_checker.sv
verif/catmull_rom_spline_eval_tb.sv
